FILE: sv/tcsm_pkg.sv
package tcsm_pkg;

  localparam int SAMPLE_DEPTH = 32768;
  localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
  localparam int SAMPLE_W     = 8;
  localparam int ADDR_W       = 15;

  localparam int VOICE_COUNT  = 2;
  localparam int VOICE_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  localparam int POS_W        = 32;
  localparam int FRAC_BITS    = 12;
  localparam int INC_W        = 16;
  localparam int VOL_W        = 7;
  localparam int END_W        = 28;
  localparam int SPAN_W       = 28;
  localparam int ACC_W        = 16;
  localparam int OUT_SHIFT    = 8;

  localparam int CFG_DW       = 32;
  localparam int CFG_LSB      = 2;
  localparam int CFG_FLD_W    = 2;
  localparam int CFG_AW       = CFG_LSB + CFG_FLD_W + VOICE_W;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_MIX   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                        operation;
    logic                       voice;
    logic [ADDR_W-1:0]          address;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic [VOICE_COUNT-1:0]     active_mask;
  } out_item_t;

  typedef struct packed {
    logic [INC_W-1:0]  inc;
    logic [VOL_W-1:0]  vol;
    logic [END_W-1:0]  end_pos;
    logic [SPAN_W-1:0] span;
  } voice_cfg_t;

endpackage

FILE: sv/two_channel_sample_mixer.sv
// Two-voice sample-playback mixer over a shared signed 8-bit sample memory.
// Input transactions on in_valid/in_ready carry an operation: write one sample
// into memory, start a voice at a base address, stop a voice, or mix one tick.
// Only a mix tick produces an output transaction on out_valid/out_ready,
// carrying the mixed sample and the mask of voices still playing.
// Voice registers (increment, volume, end, loop span) sit on the APB port. The
// user must write them only while the block is idle; the block does not enforce it.
// Write, start and stop are each taken in the idle state. A mix tick occupies
// the block for an address state per voice, plus a multiply-accumulate and a
// wrap state per active voice, plus a wait on the shared bit-serial remainder
// unit for each voice that overshoots its end by a full loop span or more.
// Each voice takes its memory read and its multiply-accumulate in turn over
// the single memory port; after the last voice the emit state loads the output
// register and out_valid together.
// The finished result waits in an output register. A mix tick accepted while
// the receiver stalls is still computed, then holds the block in its emit
// state, with in_ready low for every operation, until the old result is taken.
// Reset is synchronous: all voices stop, positions and registers clear, and
// the output channel empties. The sample memory is not cleared.
module two_channel_sample_mixer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tcsm_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tcsm_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcsm_pkg::CFG_AW-1:0] paddr,
  input  logic [tcsm_pkg::CFG_DW-1:0] pwdata,
  output logic [tcsm_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import tcsm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_MAC,
    S_WRAP,
    S_REM,
    S_EMIT
  } state_t;

  state_t                     state_r;
  logic [VOICE_W-1:0]         v_r;
  logic [VOICE_COUNT-1:0]     active_r;
  logic [POS_W-1:0]           pos_r  [VOICE_COUNT];
  logic [ADDR_W-1:0]          base_r [VOICE_COUNT];
  logic [POS_W-1:0]           pos_new_r;
  logic [POS_W:0]             diff_r;
  logic [ACC_W-1:0]           acc_r;
  logic                       out_valid_r;
  out_item_t                  out_data_r;

  voice_cfg_t [VOICE_COUNT-1:0] voice_cfg;
  voice_cfg_t                 cur_cfg;
  logic [POS_W-1:0]           cur_pos;
  logic [SAMPLE_AW-1:0]       rd_addr;
  logic [SAMPLE_AW-1:0]       mem_addr;
  logic                       mem_we;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [ACC_W-1:0]    prod;
  logic [POS_W-1:0]           loop_base;
  logic                       span_zero;
  logic                       wrap_fast;
  logic                       rem_start;
  logic                       rem_done;
  logic [SPAN_W-1:0]          rem_val;
  logic                       last_voice;
  logic                       in_fire;
  logic                       emit_go;

  assign in_fire    = in_valid & in_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign cur_cfg    = voice_cfg[v_r];
  assign cur_pos    = pos_r[v_r];
  assign rd_addr    = SAMPLE_AW'(base_r[v_r]) + cur_pos[FRAC_BITS +: SAMPLE_AW];
  assign mem_addr   = (state_r == S_IDLE) ? in_data.address[SAMPLE_AW-1:0] : rd_addr;
  assign mem_we     = in_fire && (in_data.operation == OP_WRITE);
  assign prod       = $signed(rd_data) * $signed({1'b0, cur_cfg.vol});
  assign loop_base  = POS_W'(cur_cfg.end_pos) - POS_W'(cur_cfg.span);
  assign span_zero  = (cur_cfg.span == '0);
  assign wrap_fast  = (diff_r[POS_W-1:0] < POS_W'(cur_cfg.span));
  // Overshoot by a full span or more needs the remainder unit.
  assign rem_start  = (state_r == S_WRAP) && !diff_r[POS_W] && !span_zero && !wrap_fast;
  assign last_voice = (v_r == VOICE_W'(VOICE_COUNT - 1));
  assign emit_go    = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  tcsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .voice_cfg (voice_cfg)
  );

  tcsm_sample_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .addr    (mem_addr),
    .wr_data (in_data.sample_value),
    .rd_data (rd_data)
  );

  tcsm_rem_unit u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (diff_r[POS_W-1:0]),
    .divisor   (cur_cfg.span),
    .done      (rem_done),
    .remainder (rem_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      v_r         <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        pos_r[i]  <= '0;
        base_r[i] <= '0;
      end
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_data.operation)
              OP_WRITE: begin
              end
              OP_START: begin
                base_r[in_data.voice]   <= in_data.address;
                pos_r[in_data.voice]    <= '0;
                active_r[in_data.voice] <= 1'b1;
              end
              OP_STOP: begin
                active_r[in_data.voice] <= 1'b0;
              end
              OP_MIX: begin
                acc_r   <= '0;
                v_r     <= '0;
                state_r <= S_ADDR;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADDR: begin
          if (active_r[v_r]) begin
            pos_new_r <= cur_pos + POS_W'(cur_cfg.inc);
            state_r   <= S_MAC;
          end else if (last_voice) begin
            state_r <= S_EMIT;
          end else begin
            v_r <= v_r + 1'b1;
          end
        end
        S_MAC: begin
          acc_r   <= acc_r + ACC_W'(prod);
          diff_r  <= {1'b0, pos_new_r} - (POS_W + 1)'(cur_cfg.end_pos);
          state_r <= S_WRAP;
        end
        S_WRAP: begin
          if (rem_start) begin
            state_r <= S_REM;
          end else begin
            if (diff_r[POS_W]) begin
              pos_r[v_r] <= pos_new_r;
            end else if (span_zero) begin
              pos_r[v_r]    <= pos_new_r;
              active_r[v_r] <= 1'b0;
            end else begin
              pos_r[v_r] <= loop_base + diff_r[POS_W-1:0];
            end
            if (last_voice) begin
              state_r <= S_EMIT;
            end else begin
              v_r     <= v_r + 1'b1;
              state_r <= S_ADDR;
            end
          end
        end
        S_REM: begin
          if (rem_done) begin
            pos_r[v_r] <= loop_base + POS_W'(rem_val);
            if (last_voice) begin
              state_r <= S_EMIT;
            end else begin
              v_r     <= v_r + 1'b1;
              state_r <= S_ADDR;
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_data_r.mixed_sample <= acc_r[OUT_SHIFT +: SAMPLE_W];
            out_data_r.active_mask  <= active_r;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_mix_starts_voice0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.operation == OP_MIX) |=> (state_r == S_ADDR && v_r == '0))
    else $error("mix tick did not start at the first voice");

  a_rem_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == S_REM))
    else $error("remainder finished outside its wait state");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("output became valid without an emit");
`endif

endmodule

FILE: sv/tcsm_cfg_regs.sv
module tcsm_cfg_regs (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [tcsm_pkg::CFG_AW-1:0]                   paddr,
  input  logic [tcsm_pkg::CFG_DW-1:0]                   pwdata,
  output logic [tcsm_pkg::CFG_DW-1:0]                   prdata,
  output logic                                          pready,
  output tcsm_pkg::voice_cfg_t [tcsm_pkg::VOICE_COUNT-1:0] voice_cfg
);
  import tcsm_pkg::*;

  typedef enum logic [CFG_FLD_W-1:0] {
    FLD_INC  = 2'd0,
    FLD_VOL  = 2'd1,
    FLD_END  = 2'd2,
    FLD_SPAN = 2'd3
  } field_t;

  voice_cfg_t [VOICE_COUNT-1:0] cfg_r;
  field_t                       fld;
  logic [VOICE_W-1:0]           vsel;
  logic                         wr_en;
  voice_cfg_t                   rd_cfg;

  assign fld    = field_t'(paddr[CFG_LSB +: CFG_FLD_W]);
  assign vsel   = paddr[CFG_LSB + CFG_FLD_W +: VOICE_W];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (fld)
        FLD_INC:  cfg_r[vsel].inc     <= pwdata[INC_W-1:0];
        FLD_VOL:  cfg_r[vsel].vol     <= pwdata[VOL_W-1:0];
        FLD_END:  cfg_r[vsel].end_pos <= pwdata[END_W-1:0];
        FLD_SPAN: cfg_r[vsel].span    <= pwdata[SPAN_W-1:0];
        default:  cfg_r[vsel].span    <= pwdata[SPAN_W-1:0];
      endcase
    end
  end

  always_comb begin
    rd_cfg = cfg_r[vsel];
    unique case (fld)
      FLD_INC:  prdata = CFG_DW'(rd_cfg.inc);
      FLD_VOL:  prdata = CFG_DW'(rd_cfg.vol);
      FLD_END:  prdata = CFG_DW'(rd_cfg.end_pos);
      FLD_SPAN: prdata = CFG_DW'(rd_cfg.span);
      default:  prdata = '0;
    endcase
  end

  assign voice_cfg = cfg_r;

endmodule

FILE: sv/tcsm_sample_mem.sv
module tcsm_sample_mem (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [tcsm_pkg::SAMPLE_AW-1:0]       addr,
  input  logic signed [tcsm_pkg::SAMPLE_W-1:0] wr_data,
  output logic signed [tcsm_pkg::SAMPLE_W-1:0] rd_data
);
  import tcsm_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  // Single port: a write and a read never share a cycle in practice.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/tcsm_rem_unit.sv
module tcsm_rem_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tcsm_pkg::POS_W-1:0]    dividend,
  input  logic [tcsm_pkg::SPAN_W-1:0]   divisor,
  output logic                          done,
  output logic [tcsm_pkg::SPAN_W-1:0]   remainder
);
  import tcsm_pkg::*;

  localparam int CNT_W = $clog2(POS_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [POS_W-1:0]  dvd_r;
  logic [SPAN_W-1:0] dsr_r;
  logic [SPAN_W-1:0] rem_r;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   trial_sub;
  logic              trial_ge;
  logic              last_step;

  // Restoring remainder, one dividend bit per cycle.
  assign trial     = {rem_r, dvd_r[POS_W-1]};
  assign trial_ge  = (trial >= {1'b0, dsr_r});
  assign trial_sub = trial - {1'b0, dsr_r};
  assign last_step = (cnt_r == CNT_W'(POS_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        dvd_r <= dvd_r << 1;
        rem_r <= trial_ge ? trial_sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import tcsm_pkg::*;

  localparam int unsigned VOL_MAX = 64;
  localparam int unsigned POS_MAX = 1 << 27;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
  localparam int REGS_PER_VOICE = 4;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 190;
  localparam int TIMEOUT_NS = 8_000_000;

  typedef enum int {REG_INC, REG_VOL, REG_END, REG_SPAN} reg_field_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  two_channel_sample_mixer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Mirror of the mixer: sample memory, voice state and voice registers.
  logic signed [SAMPLE_W-1:0] smem [0:SAMPLE_DEPTH-1];
  bit                         smem_written [0:SAMPLE_DEPTH-1];
  logic [POS_W-1:0]           voice_pos [VOICE_COUNT];
  logic [ADDR_W-1:0]          voice_base [VOICE_COUNT];
  bit                         voice_on [VOICE_COUNT];
  voice_cfg_t                 voice_regs [VOICE_COUNT];

  out_item_t expected_mix [$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        receiver_hold = 0;
  bit        tx_steady = 0;
  bit        rx_steady = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic logic [ADDR_W-1:0] read_addr(int v);
    logic [31:0] sum;
    sum = 32'(voice_base[v]) + (voice_pos[v] >> FRAC_BITS);
    return sum[ADDR_W-1:0];
  endfunction

  function automatic voice_cfg_t voice_setting(int unsigned inc, int unsigned vol,
                                               int unsigned endp, int unsigned span);
    voice_cfg_t c;
    c.inc     = INC_W'(inc);
    c.vol     = VOL_W'(vol);
    c.end_pos = END_W'(endp);
    c.span    = SPAN_W'(span);
    return c;
  endfunction

  function automatic in_item_t make_item(op_t op, logic vsel, logic [ADDR_W-1:0] addr,
                                         logic [SAMPLE_W-1:0] sval);
    in_item_t it;
    it.operation    = op;
    it.voice        = vsel;
    it.address      = addr;
    it.sample_value = sval;
    return it;
  endfunction

  // One mix tick: each playing voice contributes, then steps and handles its end.
  function automatic out_item_t mix_one_tick();
    logic [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0] prod;
    logic [POS_W-1:0]        npos;
    logic [POS_W-1:0]        endp;
    logic [POS_W-1:0]        span;
    out_item_t               r;
    acc = '0;
    r = '0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (voice_on[v]) begin
        prod = smem[read_addr(v)] * $signed({1'b0, voice_regs[v].vol});
        acc  = acc + prod;
        npos = voice_pos[v] + 32'(voice_regs[v].inc);
        endp = 32'(voice_regs[v].end_pos);
        span = 32'(voice_regs[v].span);
        if (npos >= endp) begin
          if (span == 0)
            voice_on[v] = 0;
          else
            npos = endp - span + ((npos - endp) % span);
        end
        voice_pos[v] = npos;
      end
    end
    for (int v = 0; v < VOICE_COUNT; v++)
      r.active_mask[v] = voice_on[v];
    r.mixed_sample = acc[ACC_W-1:OUT_SHIFT];
    return r;
  endfunction

  task automatic apply_item(in_item_t it);
    int gap;
    int v;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    v = int'(it.voice);
    case (it.operation)
      OP_WRITE: begin
        smem[it.address] = it.sample_value;
        smem_written[it.address] = 1;
      end
      OP_START: begin
        if (v < VOICE_COUNT) begin
          voice_base[v] = it.address;
          voice_pos[v]  = '0;
          voice_on[v]   = 1;
        end
      end
      OP_STOP: begin
        if (v < VOICE_COUNT)
          voice_on[v] = 0;
      end
      OP_MIX: expected_mix.push_back(mix_one_tick());
    endcase
  endtask

  // Any sample a playing voice is about to read gets written first.
  task automatic tick_mix();
    logic [ADDR_W-1:0] a;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      a = read_addr(v);
      if (voice_on[v] && !smem_written[a])
        apply_item(make_item(OP_WRITE, 1'($urandom), a, SAMPLE_W'($urandom)));
    end
    apply_item(make_item(OP_MIX, 1'($urandom), ADDR_W'($urandom), SAMPLE_W'($urandom)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(int v, reg_field_t f, logic [CFG_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'((v * REGS_PER_VOICE + int'(f)) << CFG_LSB);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (f)
      REG_INC:  voice_regs[v].inc     = val[INC_W-1:0];
      REG_VOL:  voice_regs[v].vol     = val[VOL_W-1:0];
      REG_END:  voice_regs[v].end_pos = val[END_W-1:0];
      REG_SPAN: voice_regs[v].span    = val[SPAN_W-1:0];
    endcase
  endtask

  task automatic program_voices(voice_cfg_t c0, voice_cfg_t c1);
    voice_cfg_t c;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      c = (v == 0) ? c0 : c1;
      reg_write(v, REG_INC, 32'(c.inc));
      reg_write(v, REG_VOL, 32'(c.vol));
      reg_write(v, REG_END, 32'(c.end_pos));
      reg_write(v, REG_SPAN, 32'(c.span));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic voice_cfg_t rand_voice_cfg();
    int unsigned inc, vol, endp, span;
    case ($urandom_range(0, 3))
      0: inc = 0;
      1: inc = 16'hFFFF;
      2: inc = $urandom_range(0, 8191);
      default: inc = $urandom_range(0, 16'hFFFF);
    endcase
    case ($urandom_range(0, 2))
      0: vol = 0;
      1: vol = VOL_MAX;
      default: vol = $urandom_range(0, VOL_MAX);
    endcase
    case ($urandom_range(0, 4))
      0: endp = 0;
      1: endp = POS_MAX;
      2, 3: endp = $urandom_range(1 << FRAC_BITS, 64 << FRAC_BITS);
      default: endp = $urandom_range(0, POS_MAX);
    endcase
    case ($urandom_range(0, 4))
      0: span = 0;
      1: span = POS_MAX;
      2, 3: span = $urandom_range(0, endp);
      default: span = $urandom_range(0, POS_MAX);
    endcase
    return voice_setting(inc, vol, endp, span);
  endfunction

  task automatic random_item();
    int pick;
    int v;
    logic [ADDR_W-1:0] a;
    pick = $urandom_range(0, 99);
    v = $urandom_range(0, VOICE_COUNT - 1);
    if (pick < 45) begin
      tick_mix();
    end else if (pick < 65) begin
      if (voice_on[v] && $urandom_range(0, 1) == 1)
        a = read_addr(v) + ADDR_W'($urandom_range(0, 15));
      else
        a = ADDR_W'($urandom);
      apply_item(make_item(OP_WRITE, 1'($urandom), a, SAMPLE_W'($urandom)));
    end else if (pick < 82) begin
      // Bases near the top of memory make the read address wrap.
      if ($urandom_range(0, 3) == 0)
        a = ADDR_MAX - ADDR_W'($urandom_range(0, 7));
      else
        a = ADDR_W'($urandom);
      apply_item(make_item(OP_START, 1'(v), a, SAMPLE_W'($urandom)));
    end else if (pick < 92) begin
      apply_item(make_item(OP_STOP, 1'(v), ADDR_W'($urandom), SAMPLE_W'($urandom)));
    end else begin
      a = ADDR_W'($urandom);
      apply_item(make_item(OP_START, 1'b0, a, SAMPLE_W'($urandom)));
      apply_item(make_item(OP_START, 1'b1, a, SAMPLE_W'($urandom)));
    end
  endtask

  task automatic test_idle_tick();
    tick_mix();
    settle();
  endtask

  task automatic test_directed();
    apply_item(make_item(OP_WRITE, 1'b0, '0, 8'sd127));
    apply_item(make_item(OP_WRITE, 1'b1, ADDR_MAX, -8'sd128));
    apply_item(make_item(OP_WRITE, 1'b0, 15'h5555, 8'h55));
    apply_item(make_item(OP_WRITE, 1'b1, 15'h2AAA, 8'hAA));
    settle();
    // Voice 0 stops at its end; voice 1 runs at the largest step.
    program_voices(voice_setting(4096, VOL_MAX, 3 << FRAC_BITS, 0),
                   voice_setting(16'hFFFF, VOL_MAX, POS_MAX, POS_MAX));
    apply_item(make_item(OP_START, 1'b0, ADDR_MAX, 8'h00));
    apply_item(make_item(OP_START, 1'b1, 15'h5555, 8'hFF));
    repeat (4) tick_mix();
    apply_item(make_item(OP_STOP, 1'b1, '0, 8'h00));
    tick_mix();
    apply_item(make_item(OP_START, 1'b1, 15'h2AAA, 8'h00));
    repeat (2) tick_mix();
    settle();
    // A loop span above the end, and a position that wraps past the top of 32 bits.
    program_voices(voice_setting(16'hFFFF, VOL_MAX, 1 << FRAC_BITS, POS_MAX),
                   voice_setting(16'hFFFF, 1, 0, 1));
    apply_item(make_item(OP_START, 1'b0, '0, 8'h00));
    apply_item(make_item(OP_START, 1'b1, '0, 8'h00));
    repeat (3) tick_mix();
    apply_item(make_item(OP_STOP, 1'b0, ADDR_MAX, 8'hFF));
    apply_item(make_item(OP_STOP, 1'b1, ADDR_MAX, 8'hFF));
    tick_mix();
    settle();
  endtask

  task automatic test_output_stall();
    program_voices(voice_setting(3000, VOL_MAX, 40 << FRAC_BITS, 24 << FRAC_BITS),
                   voice_setting(5000, 40, 60 << FRAC_BITS, 7 << FRAC_BITS));
    apply_item(make_item(OP_START, 1'b0, ADDR_W'($urandom), 8'h00));
    apply_item(make_item(OP_START, 1'b1, ADDR_W'($urandom), 8'h00));
    receiver_hold = LONG_HOLD;
    repeat (40) tick_mix();
    settle();
  endtask

  task automatic test_sender_pause();
    program_voices(rand_voice_cfg(), rand_voice_cfg());
    repeat (30) random_item();
    settle();
    tx_steady = 1;
    rx_steady = 1;
    repeat (60) random_item();
    tx_steady = 0;
    rx_steady = 0;
    settle();
  endtask

  task automatic test_random_traffic();
    int goal;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_voices(rand_voice_cfg(), rand_voice_cfg());
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) random_item();
      settle();
    end
  endtask

  initial begin : result_sink
    int gap;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (receiver_hold > 0) begin
        out_ready <= 1'b0;
        repeat (receiver_hold) @(posedge clk);
        receiver_hold = 0;
      end
      gap = rx_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_mix.size() == 0) begin
        report_mismatch("transaction with no mix tick pending", 32'(out_data), '0);
      end else begin
        want = expected_mix.pop_front();
        if (out_data.mixed_sample !== want.mixed_sample)
          report_mismatch("mixed_sample", 32'(out_data.mixed_sample),
                          32'(want.mixed_sample));
        if (out_data.active_mask !== want.active_mask)
          report_mismatch("active_mask", 32'(out_data.active_mask), 32'(want.active_mask));
      end
    end
  end

  initial begin
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    rst_n    <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_tick();
    test_directed();
    test_output_stall();
    test_sender_pause();
    test_random_traffic();

    if (expected_mix.size() != 0)
      report_mismatch("mix ticks never answered", expected_mix.size(), 0);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
sv/tcsm_pkg.sv
sv/tcsm_cfg_regs.sv
sv/tcsm_sample_mem.sv
sv/tcsm_rem_unit.sv
sv/two_channel_sample_mixer.sv
dv/tb.sv
